FILE: rtl/assert_macros.svh
// Assertion macros used by the chunked body decoder RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define HCBD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("hcbd assertion failed: invariant");

// Checks that a trigger is followed in the next clock cycle by a consequence.
`define HCBD_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("hcbd assertion failed: sequence");

`endif

FILE: rtl/hcbd_pkg.sv
// Package for the HTTP chunked body decoder: widths, phase codes, result type
// and the hex digit decoder. No dependencies.
`default_nettype none

package hcbd_pkg;

  // Width of the chunk size counter; a size needing more bits is an error.
  localparam int SizeBits = 32;

  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChLf = 8'h0a;

  // Decoder phase.
  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_SKIP1 = 3'd1,
    PH_DATA  = 3'd2,
    PH_TERM  = 3'd3,
    PH_DONE  = 3'd4,
    PH_ERROR = 3'd5
  } hcbd_phase_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       chunk_end;
    logic       body_done;
    logic       format_error;
  } hcbd_result_t;

  // Decoded hex digit: valid flag and 4-bit value.
  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hcbd_hex_t;

  function automatic hcbd_hex_t hex_decode(input logic [7:0] c);
    hcbd_hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      // Letters a-f and A-F share the low three bits: 1..6 maps to 10..15.
      h.value = 4'(c[2:0]) + 4'd9;
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/http_chunked_body_decoder_unit.sv
// HTTP chunked body decoder: each input transaction passes through the input register
// and the result register; one input byte accepted per cycle when the output is not stalled.
// Each byte is held in the input register until it can move on, then the parser state and the
// result register are written together. Reset (rst_n, synchronous, active low)
// empties both registers and returns the parser to a fresh size line, no error.
// Depends on hcbd_pkg, hcbd_parser, hcbd_out_reg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module http_chunked_body_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_data_byte,
  output logic            out_data_valid,
  output logic            out_chunk_end,
  output logic            out_body_done,
  output logic            out_format_error
);

  logic                   s0_valid_r;
  logic [7:0]             s0_byte_r;
  logic                   adv;
  logic                   in_take;
  hcbd_pkg::hcbd_result_t cur_res;
  hcbd_pkg::hcbd_result_t out_res;

  // The held byte moves on when the result register is empty or being taken.
  assign adv      = s0_valid_r && (!out_valid || !out_stall);
  assign in_stall = s0_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_take) begin
      s0_valid_r <= 1'b1;
    end else if (adv) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_byte_r <= in_byte;
    end
  end

  hcbd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_byte (s0_byte_r),
    .res     (cur_res)
  );

  hcbd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res_in    (cur_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign out_data_byte    = out_res.data_byte;
  assign out_data_valid   = out_res.data_valid;
  assign out_chunk_end    = out_res.chunk_end;
  assign out_body_done    = out_res.body_done;
  assign out_format_error = out_res.format_error;

  // A chunk end is always a payload byte.
  `HCBD_ASSERT_ALWAYS(a_chunk_end_is_data, !(out_valid && out_chunk_end && !out_data_valid))
  // No payload passes once a format error has been raised.
  `HCBD_ASSERT_ALWAYS(a_no_data_after_error, !(out_valid && out_format_error && out_data_valid))
  // The input side only stalls while a byte is held.
  `HCBD_ASSERT_ALWAYS(a_stall_needs_byte, !(in_stall && !s0_valid_r))
  // Once the body is done, every later result also reports it.
  `HCBD_ASSERT_NEXT(a_done_sticky, adv && cur_res.body_done, cur_res.body_done)

endmodule

`default_nettype wire

FILE: rtl/hcbd_parser.sv
// Framing parser of the chunked body decoder: holds the parse state and
// computes one result per byte. Depends on hcbd_pkg.
`default_nettype none

module hcbd_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic [7:0]            in_byte,
  output hcbd_pkg::hcbd_result_t     res
);

  hcbd_pkg::hcbd_phase_t             phase_r, phase_nxt;
  logic [hcbd_pkg::SizeBits-1:0]     remaining_r, remaining_nxt;
  logic                              digit_seen_r, digit_seen_nxt;
  logic                              skip_line_r, skip_line_nxt;
  logic [1:0]                        skip_count_r, skip_count_nxt;
  logic                              error_r, error_nxt;
  hcbd_pkg::hcbd_hex_t               hex;
  logic                              is_eol;
  logic                              size_full;

  assign hex       = hcbd_pkg::hex_decode(in_byte);
  assign is_eol    = (in_byte == hcbd_pkg::ChCr) || (in_byte == hcbd_pkg::ChLf);
  // Another digit would push a set bit past the top of the counter.
  assign size_full = |remaining_r[hcbd_pkg::SizeBits-1 -: 4];

  // Next state for the current byte.
  always_comb begin
    phase_nxt      = phase_r;
    remaining_nxt  = remaining_r;
    digit_seen_nxt = digit_seen_r;
    skip_line_nxt  = skip_line_r;
    skip_count_nxt = skip_count_r;
    error_nxt      = error_r;
    case (phase_r)
      hcbd_pkg::PH_SIZE: begin
        if (is_eol) begin
          if (!digit_seen_r) begin
            error_nxt = 1'b1;
            phase_nxt = hcbd_pkg::PH_ERROR;
          end else if (remaining_r == '0) begin
            phase_nxt = hcbd_pkg::PH_DONE;
          end else begin
            phase_nxt = hcbd_pkg::PH_SKIP1;
          end
        end else if (!skip_line_r) begin
          if (!hex.is_hex) begin
            skip_line_nxt = 1'b1;
          end else if (size_full) begin
            error_nxt = 1'b1;
            phase_nxt = hcbd_pkg::PH_ERROR;
          end else begin
            remaining_nxt  = {remaining_r[hcbd_pkg::SizeBits-5:0], hex.value};
            digit_seen_nxt = 1'b1;
          end
        end
      end
      hcbd_pkg::PH_SKIP1: begin
        phase_nxt = hcbd_pkg::PH_DATA;
      end
      hcbd_pkg::PH_DATA: begin
        remaining_nxt = remaining_r - 1'b1;
        if (remaining_r == hcbd_pkg::SizeBits'(1)) begin
          phase_nxt      = hcbd_pkg::PH_TERM;
          skip_count_nxt = 2'd2;
        end
      end
      hcbd_pkg::PH_TERM: begin
        skip_count_nxt = skip_count_r - 2'd1;
        if (skip_count_nxt == 2'd0) begin
          // Start a fresh size line.
          phase_nxt      = hcbd_pkg::PH_SIZE;
          remaining_nxt  = '0;
          digit_seen_nxt = 1'b0;
          skip_line_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Result fields for the current byte.
  always_comb begin
    res.data_byte    = 8'd0;
    res.data_valid   = 1'b0;
    res.chunk_end    = 1'b0;
    if (phase_r == hcbd_pkg::PH_DATA) begin
      res.data_byte  = in_byte;
      res.data_valid = 1'b1;
      res.chunk_end  = (remaining_r == hcbd_pkg::SizeBits'(1));
    end
    res.body_done    = (phase_nxt == hcbd_pkg::PH_DONE);
    res.format_error = error_nxt;
  end

  // State advances only when the byte moves on to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= hcbd_pkg::PH_SIZE;
      remaining_r  <= '0;
      digit_seen_r <= 1'b0;
      skip_line_r  <= 1'b0;
      skip_count_r <= 2'd0;
      error_r      <= 1'b0;
    end else if (adv) begin
      phase_r      <= phase_nxt;
      remaining_r  <= remaining_nxt;
      digit_seen_r <= digit_seen_nxt;
      skip_line_r  <= skip_line_nxt;
      skip_count_r <= skip_count_nxt;
      error_r      <= error_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hcbd_out_reg.sv
// Result register of the chunked body decoder with valid/stall handshake.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire hcbd_pkg::hcbd_result_t res_in,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output hcbd_pkg::hcbd_result_t     res_out
);

  logic                   valid_r;
  hcbd_pkg::hcbd_result_t res_r;

  // Valid is set on load and cleared once the transaction is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Payload holds while stalled.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

FILE: verif/http_chunked_body_decoder_unit_test.sv
// Self-checking testbench for http_chunked_body_decoder_unit: a chunked body
// goes in a byte at a time and every result is checked against a local decoder.
// Depends on hcbd_pkg and the RTL of the decoder.
`default_nettype none

module http_chunked_body_decoder_unit_test;
  import hcbd_pkg::*;

  // Ways in which the one body of this run can end.
  typedef enum int {
    END_ZERO_SIZE,
    END_NO_DIGITS,
    END_OVERFLOW
  } body_end_t;

  // Receiver stall styles, switched at random while the body is sent.
  typedef enum int {
    RX_FREE,
    RX_SPARSE,
    RX_PATTERN,
    RX_HEAVY
  } stall_mode_t;

  localparam int IdleLimit  = 2000;
  localparam int HoldStart  = 400;
  localparam int HoldCycles = 150;
  localparam int BodyBytes  = 1880;

  // Tracks the decoder: each accepted byte yields one decoded result, which is
  // queued until the matching output transaction arrives.
  class dechunk_scoreboard;
    hcbd_phase_t         stage;
    logic [SizeBits-1:0] count;
    bit                  have_digit;
    bit                  in_extension;
    int unsigned         term_left;
    bit                  sticky_err;
    hcbd_result_t        decoded_q[$];
    int unsigned         mismatches;
    int unsigned         checked;
    int unsigned         payload_seen;
    int unsigned         chunks_seen;

    function new();
      open_size_line();
      sticky_err   = 1'b0;
      mismatches   = 0;
      checked      = 0;
      payload_seen = 0;
      chunks_seen  = 0;
    endfunction

    function void open_size_line();
      stage        = PH_SIZE;
      count        = '0;
      have_digit   = 1'b0;
      in_extension = 1'b0;
      term_left    = 0;
    endfunction

    // Returns 1 and the nibble value when c is an ASCII hex digit.
    function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= "0" && c <= "9") begin
        v = c[3:0];
        return 1'b1;
      end
      if (c >= "a" && c <= "f") begin
        v = 4'(c - "a" + 8'd10);
        return 1'b1;
      end
      if (c >= "A" && c <= "F") begin
        v = 4'(c - "A" + 8'd10);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Advances the decoder by one accepted byte and queues its result.
    function void note_byte(input logic [7:0] b);
      hcbd_result_t r;
      logic [3:0]   v;
      r = '0;
      case (stage)
        PH_SIZE: begin
          if (b == ChCr || b == ChLf) begin
            if (!have_digit) begin
              sticky_err = 1'b1;
              stage      = PH_ERROR;
            end else if (count == 0) begin
              stage = PH_DONE;
            end else begin
              stage = PH_SKIP1;
            end
          end else if (!in_extension) begin
            if (!hex_nibble(b, v)) begin
              in_extension = 1'b1;
            end else if (count[SizeBits-1 -: 4] != 0) begin
              // One more digit would not fit in the size counter.
              sticky_err = 1'b1;
              stage      = PH_ERROR;
            end else begin
              count      = {count[SizeBits-5:0], v};
              have_digit = 1'b1;
            end
          end
        end
        PH_SKIP1: stage = PH_DATA;
        PH_DATA: begin
          r.data_byte  = b;
          r.data_valid = 1'b1;
          count        = count - 1'b1;
          if (count == 0) begin
            r.chunk_end = 1'b1;
            stage       = PH_TERM;
            term_left   = 2;
          end
        end
        PH_TERM: begin
          term_left--;
          if (term_left == 0) begin
            open_size_line();
          end
        end
        default: ;
      endcase
      r.body_done    = (stage == PH_DONE);
      r.format_error = sticky_err;
      decoded_q.push_back(r);
    endfunction

    task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("ERROR: result %0d: %s: got %h, expected %h", checked, what, got, want);
      mismatches++;
    endtask

    // Compares one output transaction with the oldest decoded result.
    task check_result(input hcbd_result_t got);
      hcbd_result_t want;
      if (decoded_q.size() == 0) begin
        report_mismatch("result with no byte outstanding", 8'(got), 8'h00);
        return;
      end
      want = decoded_q.pop_front();
      if (got.data_byte !== want.data_byte)
        report_mismatch("data_byte", got.data_byte, want.data_byte);
      if (got.data_valid !== want.data_valid)
        report_mismatch("data_valid", 8'(got.data_valid), 8'(want.data_valid));
      if (got.chunk_end !== want.chunk_end)
        report_mismatch("chunk_end", 8'(got.chunk_end), 8'(want.chunk_end));
      if (got.body_done !== want.body_done)
        report_mismatch("body_done", 8'(got.body_done), 8'(want.body_done));
      if (got.format_error !== want.format_error)
        report_mismatch("format_error", 8'(got.format_error), 8'(want.format_error));
      payload_seen += want.data_valid;
      chunks_seen  += want.chunk_end;
      checked++;
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_data_byte;
  logic       out_data_valid;
  logic       out_chunk_end;
  logic       out_body_done;
  logic       out_format_error;

  dechunk_scoreboard sb;
  logic [7:0]        body_bytes[$];
  body_end_t         ending;

  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  stall_mode_t rx_mode = RX_FREE;
  logic [7:0]  rx_mask = 8'h00;
  logic        stall_next;
  int unsigned idle_cycles = 0;

  http_chunked_body_decoder_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_data_valid   (out_data_valid),
    .out_chunk_end    (out_chunk_end),
    .out_body_done    (out_body_done),
    .out_format_error (out_format_error)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return "0" + 8'(v);
    return (upper ? "A" : "a") + 8'(v) - 8'd10;
  endfunction

  // A byte that starts a chunk extension: neither a hex digit nor a line end.
  function automatic logic [7:0] junk_byte();
    logic [7:0] c;
    logic [3:0] v;
    do begin
      c = 8'($urandom_range(255));
    end while (sb.hex_nibble(c, v) || c == ChCr || c == ChLf);
    return c;
  endfunction

  // Size line: optional leading zeros, the size in hex, an optional extension
  // that may itself hold hex digits, then a CR or LF.
  task automatic add_size_line(input logic [SizeBits-1:0] size, input int unsigned zeros,
                               input bit ext);
    int unsigned ndig;
    int unsigned nmore;
    logic [7:0]  c;
    ndig = 1;
    while (ndig < SizeBits / 4 && (size >> (4 * ndig)) != 0) ndig++;
    repeat (zeros) body_bytes.push_back("0");
    for (int i = ndig - 1; i >= 0; i--) begin
      body_bytes.push_back(hex_char(size[4*i +: 4], 1'($urandom_range(1))));
    end
    if (ext) begin
      body_bytes.push_back(junk_byte());
      nmore = $urandom_range(5);
      repeat (nmore) begin
        do c = 8'($urandom_range(255)); while (c == ChCr || c == ChLf);
        body_bytes.push_back(c);
      end
    end
    body_bytes.push_back($urandom_range(1) ? ChCr : ChLf);
  endtask

  // One complete nonzero chunk with random framing and payload.
  task automatic add_chunk(input int unsigned size);
    add_size_line(size, ($urandom_range(3) == 0) ? $urandom_range(6, 1) : 0,
                  $urandom_range(3) == 0);
    body_bytes.push_back($urandom_range(1) ? ChLf : 8'($urandom_range(255)));
    repeat (size) body_bytes.push_back(8'($urandom_range(255)));
    if ($urandom_range(1)) begin
      body_bytes.push_back(ChCr);
      body_bytes.push_back(ChLf);
    end else begin
      body_bytes.push_back(8'($urandom_range(255)));
      body_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic build_body();
    logic [7:0]  opening[] = '{
      "1", ChCr, ChLf, 8'h00, ChCr, ChLf,
      "0", "2", ";", "f", ChLf, 8'hff, 8'hff, 8'h80, 8'h00, 8'hff
    };
    int unsigned pick;
    int unsigned nsig;
    // Directed opening: a one-byte chunk of zero, then a chunk with a leading
    // zero, an extension holding a hex digit, an LF-only line end and extreme
    // payload and terminator values.
    foreach (opening[i]) body_bytes.push_back(opening[i]);

    // Mostly small chunks, a few long ones.
    while (body_bytes.size() < BodyBytes) begin
      pick = $urandom_range(99);
      if (pick < 80) add_chunk($urandom_range(16, 1));
      else if (pick < 95) add_chunk($urandom_range(64, 17));
      else add_chunk($urandom_range(300, 65));
    end

    // The body can end only once per reset, so the ending is drawn at random.
    ending = body_end_t'($urandom_range(2));
    case (ending)
      END_ZERO_SIZE: add_size_line('0, $urandom_range(3), 1'($urandom_range(1)));
      END_NO_DIGITS: begin
        if ($urandom_range(1)) begin
          body_bytes.push_back(junk_byte());
          body_bytes.push_back(hex_char(4'($urandom_range(15)), 1'b0));
        end
        body_bytes.push_back($urandom_range(1) ? ChCr : ChLf);
      end
      default: begin
        // Nine or more significant digits; the ninth does not fit.
        repeat ($urandom_range(2)) body_bytes.push_back("0");
        nsig = $urandom_range(12, 9);
        body_bytes.push_back(hex_char(4'($urandom_range(15, 1)), 1'($urandom_range(1))));
        repeat (nsig - 1) body_bytes.push_back(hex_char(4'($urandom_range(15)),
                                                        1'($urandom_range(1))));
        body_bytes.push_back(ChCr);
      end
    endcase

    // Bytes after the end of the body must all be ignored.
    repeat (24) body_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Offers the body in bursts with random gaps; some bursts run long.
  task automatic send_body();
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;
    idx = 0;
    while (idx < body_bytes.size()) begin
      burst = ($urandom_range(7) == 0) ? $urandom_range(300, 60) : $urandom_range(40, 1);
      gap   = $urandom_range(12, 1);
      while (burst != 0 && idx < body_bytes.size()) begin
        in_valid <= 1'b1;
        in_byte  <= body_bytes[idx];
        do @(posedge clk); while (in_stall);
        sb.note_byte(body_bytes[idx]);
        idx++;
        burst--;
      end
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: check each accepted transaction, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_data_byte, out_data_valid, out_chunk_end, out_body_done,
                       out_format_error});
    end
    rx_cycle++;
    if (rx_cycle % 64 == 0) begin
      rx_mode = stall_mode_t'($urandom_range(3));
      rx_mask = 8'($urandom);
    end
    // One long hold-off lets the decoder fill up and stall its input.
    if (rx_cycle == HoldStart) hold_left = HoldCycles;
    if (hold_left != 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE:    stall_next = 1'b0;
        RX_SPARSE:  stall_next = ($urandom_range(2) == 0);
        RX_PATTERN: stall_next = rx_mask[rx_cycle % 8];
        default:    stall_next = ($urandom_range(2) != 0);
      endcase
    end
    out_stall <= stall_next;
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no transaction for %0d cycles", IdleLimit);
      $display("http_chunked_body_decoder_unit: mismatch");
      $finish;
    end
  end

  initial begin
    sb = new();
    build_body();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_body();
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Decoded %0d body bytes: %0d chunks, %0d payload bytes, %0d results checked.",
             body_bytes.size(), sb.chunks_seen, sb.payload_seen, sb.checked);
    $display("Body ended by %s; the receiver held off once for %0d cycles.",
             ending.name(), HoldCycles);
    if (sb.mismatches == 0) begin
      $display("http_chunked_body_decoder_unit: match");
    end else begin
      $display("http_chunked_body_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
